/* rtl/cfilt_pkg.sv */
package cfilt_pkg;

    localparam int DATA_W      = 16;             // raw sample width
    localparam int NUM_W       = DATA_W + 1;     // negated axis needs one more bit
    localparam int SUMSQ_W     = 2 * DATA_W;     // a^2 + b^2
    localparam int ROOT_W      = 30;             // floor(sqrt(sumsq * 2^28))
    localparam int REM_W       = ROOT_W + 5;     // root remainder with headroom
    localparam int CX_W        = 34;             // CORDIC x/y datapath
    localparam int ZW          = 25;             // CORDIC angle, Q16 degrees
    localparam int TABLE_LEN   = 24;
    localparam int TIDX_W      = 5;              // index into the arctangent table
    localparam int DEN_W       = 23;             // sensitivity * 100
    localparam int QUO_W       = 48;             // dividend / quotient shifter
    localparam int INCR_W      = 43;             // signed gyro increment
    localparam int ACC_W       = 64;             // blend accumulator
    localparam int ALPHA_W     = 17;
    localparam int SENS_W      = 16;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int ANGLE_LIMIT = 23040;          // 180 deg in 1/128 deg
    localparam int OUT_SHIFT   = 25;             // Q32 -> 1/128 degree

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [ALPHA_W-1:0] BLEND_WEIGHT_RST = 17'd64225;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE        = 17'd65536;
    localparam logic [SENS_W-1:0]  GYRO_SENS_RST    = 16'd655;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SENS    = 2'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic signed [DATA_W-1:0] accel_z;
        logic signed [DATA_W-1:0] gyro_x;
        logic signed [DATA_W-1:0] gyro_y;
        logic        [DATA_W-1:0] dt_ms;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] angle_x;
        logic signed [DATA_W-1:0] angle_y;
    } angle_t;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_ROOT,
        LANE_ATAN,
        LANE_JOIN,
        LANE_BLEND
    } lane_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_RUN,
        TOP_HOLD
    } top_state_t;

    // atan(2^-i) in Q16 degrees, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q16(input logic [TIDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] mag16(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 16'd1) : v;
    endfunction

endpackage

/* rtl/cfilt_sqrt.sv */
// sqrt((a^2 + b^2) * 2^28): serial squaring, then one root bit per cycle
module cfilt_sqrt
    import cfilt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic                     done,
    output logic [ROOT_W-1:0]        root
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                sq_reg, sq_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [DATA_W-1:0]   ma_reg, ma_next, mb_reg, mb_next;
    logic [SUMSQ_W-1:0]  ca_reg, ca_next, cb_reg, cb_next;
    logic [SUMSQ_W-1:0]  sum_reg, sum_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W-1:0]    r2, trial;

    assign r2    = {rem_reg[REM_W-3:0], sum_reg[SUMSQ_W-1 -: 2]};
    assign trial = REM_W'({root_reg, 2'b01});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        ca_next   = ca_reg;
        cb_next   = cb_reg;
        sum_next  = sum_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            sq_next   = 1'b1;
            cnt_next  = '0;
            ma_next   = mag16(a);
            mb_next   = mag16(b);
            ca_next   = SUMSQ_W'(mag16(a));
            cb_next   = SUMSQ_W'(mag16(b));
            sum_next  = '0;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            if (sq_reg)
            begin
                sum_next = sum_reg + (ma_reg[0] ? ca_reg : '0) + (mb_reg[0] ? cb_reg : '0);
                ma_next  = ma_reg >> 1;
                mb_next  = mb_reg >> 1;
                ca_next  = ca_reg << 1;
                cb_next  = cb_reg << 1;
                if (cnt_reg == 5'(DATA_W - 1))
                begin
                    sq_next  = 1'b0;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            else
            begin
                // two radicand bits in, one root bit out; zeros follow the sum
                sum_next = sum_reg << 2;
                if (r2 >= trial)
                begin
                    rem_next  = r2 - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = r2;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == 5'(ROOT_W - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sq_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            sq_reg   <= sq_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/cfilt_cordic.sv */
// vectoring CORDIC, one micro-rotation per cycle
module cfilt_cordic
    import cfilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ROOT_W-1:0]       x0,
    input  logic signed [NUM_W-1:0] num,
    output logic                    done,
    output logic signed [ZW-1:0]    z
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [TIDX_W-1:0]       cnt_reg, cnt_next;
    logic                    zero_reg, zero_next;
    logic signed [CX_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]    z_reg, z_next;
    logic signed [CX_W-1:0]  dx, dy;
    logic signed [ZW-1:0]    step_angle;

    assign dx         = y_reg >>> cnt_reg;
    assign dy         = x_reg >>> cnt_reg;
    assign step_angle = atan_q16(cnt_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        zero_next = zero_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            zero_next = (x0 == '0) && (num == '0);
            x_next    = CX_W'(x0);
            y_next    = {{(CX_W - NUM_W - 14){num[NUM_W-1]}}, num, 14'b0};
            z_next    = '0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[CX_W-1])
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + step_angle;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - step_angle;
            end
            if (cnt_reg == TIDX_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // zero vector: angle defined as zero
    assign done = done_reg;
    assign z    = zero_reg ? '0 : z_reg;

endmodule

/* rtl/cfilt_div.sv */
// gyro increment: serial |g|*dt, then restoring divide by sens*100 with rounding
module cfilt_div
    import cfilt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] g,
    input  logic [DATA_W-1:0]        dt,
    input  logic [DEN_W-1:0]         den,
    output logic                     done,
    output logic signed [INCR_W-1:0] incr
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                mul_reg, mul_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [DATA_W-1:0]   mg_reg, mg_next;
    logic [SUMSQ_W-1:0]  mc_reg, mc_next, prod_reg, prod_next;
    logic [QUO_W-1:0]    nq_reg, nq_next;
    logic [DEN_W-1:0]    rem_reg, rem_next, den_reg, den_next;
    logic                neg_reg, neg_next;
    logic [DEN_W:0]      r2;
    logic                ge;
    logic [INCR_W-1:0]   mag;

    assign r2  = {rem_reg, nq_reg[QUO_W-1]};
    assign ge  = r2 >= {1'b0, den_reg};
    assign mag = {1'b0, nq_reg[INCR_W-2:0]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mul_next  = mul_reg;
        cnt_next  = cnt_reg;
        mg_next   = mg_reg;
        mc_next   = mc_reg;
        prod_next = prod_reg;
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            mul_next  = 1'b1;
            cnt_next  = '0;
            mg_next   = mag16(g);
            mc_next   = SUMSQ_W'(dt);
            prod_next = '0;
            rem_next  = '0;
            den_next  = den;
            neg_next  = g[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (mul_reg)
            begin
                prod_next = prod_reg + (mg_reg[0] ? mc_reg : '0);
                mg_next   = mg_reg >> 1;
                mc_next   = mc_reg << 1;
                if (cnt_reg == 6'(DATA_W - 1))
                begin
                    mul_next = 1'b0;
                    cnt_next = '0;
                    // scale by 2^16 and add half the divisor for rounding
                    nq_next  = {prod_next, 16'b0} + QUO_W'(den_reg[DEN_W-1:1]);
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            else
            begin
                rem_next = ge ? DEN_W'(r2 - {1'b0, den_reg}) : r2[DEN_W-1:0];
                nq_next  = {nq_reg[QUO_W-2:0], ge};
                if (cnt_reg == 6'(QUO_W - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mul_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mul_reg  <= mul_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mg_reg   <= mg_next;
        mc_reg   <= mc_next;
        prod_reg <= prod_next;
        nq_reg   <= nq_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    assign done = done_reg;
    assign incr = neg_reg ? -$signed(mag) : $signed(mag);

endmodule

/* rtl/cfilt_blend.sv */
// alpha*(pred - acc) + acc*2^16, alpha one bit per cycle; round and saturate
module cfilt_blend
    import cfilt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] prev,
    input  logic signed [INCR_W-1:0] incr,
    input  logic signed [ZW-1:0]     acc,
    input  logic [ALPHA_W-1:0]       alpha,
    output logic                     done,
    output logic signed [DATA_W-1:0] angle
);

    localparam logic signed [ACC_W-1:0]  LIM_HI     = ACC_W'(ANGLE_LIMIT);
    localparam logic signed [ACC_W-1:0]  LIM_LO     = -LIM_HI;
    localparam logic signed [DATA_W-1:0] ANG_MAX    = DATA_W'(ANGLE_LIMIT);
    localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1) << (OUT_SHIFT - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic [ALPHA_W-1:0]       al_reg, al_next;
    logic signed [ACC_W-1:0]  mc_reg, mc_next, sum_reg, sum_next;
    logic signed [DATA_W-1:0] angle_reg, angle_next;
    logic signed [ACC_W-1:0]  prev_ext, incr_ext, acc_ext, shifted;

    assign prev_ext = {{(ACC_W - DATA_W - 9){prev[DATA_W-1]}}, prev, 9'b0};
    assign incr_ext = {{(ACC_W - INCR_W){incr[INCR_W-1]}}, incr};
    assign acc_ext  = {{(ACC_W - ZW){acc[ZW-1]}}, acc};
    assign shifted  = sum_next >>> OUT_SHIFT;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        al_next    = al_reg;
        mc_next    = mc_reg;
        sum_next   = sum_reg;
        angle_next = angle_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            al_next   = alpha;
            mc_next   = prev_ext + incr_ext - acc_ext;
            sum_next  = (acc_ext <<< 16) + ROUND_BIAS;
        end
        else if (busy_reg)
        begin
            sum_next = sum_reg + (al_reg[0] ? mc_reg : '0);
            mc_next  = mc_reg <<< 1;
            al_next  = al_reg >> 1;
            if (cnt_reg == 5'(ALPHA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (shifted > LIM_HI)
                    angle_next = ANG_MAX;
                else if (shifted < LIM_LO)
                    angle_next = -ANG_MAX;
                else
                    angle_next = shifted[DATA_W-1:0];
            end
            else
            begin
                cnt_next = cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        al_reg    <= al_next;
        mc_reg    <= mc_next;
        sum_reg   <= sum_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

/* rtl/cfilt_lane.sv */
// one tilt axis: root, arctangent and gyro increment, then blend into the estimate
module cfilt_lane
    import cfilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [NUM_W-1:0]  num,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    input  logic signed [DATA_W-1:0] g,
    input  logic [DATA_W-1:0]        dt,
    input  logic [DEN_W-1:0]         den,
    input  logic [ALPHA_W-1:0]       alpha,
    output logic                     done,
    output logic signed [DATA_W-1:0] angle
);

    lane_state_t              state_reg, state_next;
    logic signed [NUM_W-1:0]  num_reg;
    logic signed [DATA_W-1:0] est_reg;
    logic                     div_ready_reg;

    logic                     sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]        root;
    logic                     atan_start, atan_done;
    logic signed [ZW-1:0]     z;
    logic                     div_done;
    logic signed [INCR_W-1:0] incr;
    logic                     blend_start, blend_done;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LANE_IDLE:  if (start) state_next = LANE_ROOT;
            LANE_ROOT:  if (sqrt_done) state_next = LANE_ATAN;
            LANE_ATAN:  if (atan_done) state_next = LANE_JOIN;
            LANE_JOIN:  if (div_ready_reg || div_done) state_next = LANE_BLEND;
            LANE_BLEND: if (blend_done) state_next = LANE_IDLE;
            default:    state_next = LANE_IDLE;
        endcase
    end

    always_comb
    begin
        sqrt_start  = (state_reg == LANE_IDLE) && start;
        atan_start  = (state_reg == LANE_ROOT) && sqrt_done;
        blend_start = (state_reg == LANE_JOIN) && (div_ready_reg || div_done);
        done        = (state_reg == LANE_BLEND) && blend_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LANE_IDLE;
            est_reg       <= '0;
            div_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
                est_reg <= angle;
            if (sqrt_start)
                div_ready_reg <= 1'b0;
            else if (div_done)
                div_ready_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sqrt_start)
            num_reg <= num;
    end

    cfilt_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .a     (a),
        .b     (b),
        .done  (sqrt_done),
        .root  (root)
    );

    cfilt_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (atan_start),
        .x0    (root),
        .num   (num_reg),
        .done  (atan_done),
        .z     (z)
    );

    cfilt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .g     (g),
        .dt    (dt),
        .den   (den),
        .done  (div_done),
        .incr  (incr)
    );

    cfilt_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .prev  (est_reg),
        .incr  (incr),
        .acc   (z),
        .alpha (alpha),
        .done  (blend_done),
        .angle (angle)
    );

endmodule

/* rtl/imu_tilt_complementary_filter_unit.sv */
// Channel  | Dir | Handshake                   | Word
// ---------+-----+-----------------------------+------------------------------------------
// sample   | in  | sample_valid / sample_stall | accel_x/y/z, gyro_x/y, dt_ms (sample_t)
// angle    | out | angle_valid / angle_stall   | angle_x (roll), angle_y (pitch), angle_t
// cfg      | in  | cfg_we                      | cfg_index, cfg_data (write only)
//
// One word in flight: a new sample is accepted only after the previous result is loaded for output.
// The blend multiply waits on the later of two paths: serial squaring, root digit loop
// and CORDIC, or the gyro multiply and divide; at the default the divider finishes after
// the CORDIC and sets the join.
// Reset clears both estimates to zero and loads the register defaults.
// A finished word that finds the previous result still stalled waits in the lanes and
// keeps sample_stall high until the older one is taken; it loads in that same cycle.
module imu_tilt_complementary_filter_unit
    import cfilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              sample,
    output logic                 angle_valid,
    input  logic                 angle_stall,
    output angle_t               angle,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    top_state_t           state_reg, state_next;
    logic [ALPHA_W-1:0]   blend_weight_reg;
    logic [SENS_W-1:0]    gyro_sens_reg;
    logic                 angle_valid_reg, angle_valid_next;
    angle_t               angle_reg;

    logic                 accept, lanes_done, load_out;
    logic [ALPHA_W-1:0]   alpha;
    logic [SENS_W-1:0]    sens;
    logic [DEN_W-1:0]     den;
    logic                 done_x, done_y;
    logic signed [DATA_W-1:0] lane_x, lane_y;

    // register fixups: weight capped at 1.0, sensitivity zero acts as one
    assign alpha = (blend_weight_reg > ALPHA_ONE) ? ALPHA_ONE : blend_weight_reg;
    assign sens  = (gyro_sens_reg == '0) ? SENS_W'(1) : gyro_sens_reg;
    assign den   = DEN_W'(sens) * DEN_W'(100);

    assign accept     = sample_valid && !sample_stall;
    assign lanes_done = done_x && done_y;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TOP_IDLE: if (accept) state_next = TOP_RUN;
            TOP_RUN:
                if (lanes_done)
                    state_next = (!angle_valid_reg || !angle_stall) ? TOP_IDLE : TOP_HOLD;
            TOP_HOLD: if (!angle_stall) state_next = TOP_IDLE;
            default:  state_next = TOP_IDLE;
        endcase
    end

    always_comb
    begin
        sample_stall = (state_reg != TOP_IDLE);
        load_out     = ((state_reg == TOP_RUN) && lanes_done
                        && (!angle_valid_reg || !angle_stall))
                     || ((state_reg == TOP_HOLD) && !angle_stall);
    end

    always_comb
    begin
        if (load_out)
            angle_valid_next = 1'b1;
        else if (angle_valid_reg && !angle_stall)
            angle_valid_next = 1'b0;
        else
            angle_valid_next = angle_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= TOP_IDLE;
            angle_valid_reg  <= 1'b0;
            blend_weight_reg <= BLEND_WEIGHT_RST;
            gyro_sens_reg    <= GYRO_SENS_RST;
        end
        else
        begin
            state_reg       <= state_next;
            angle_valid_reg <= angle_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLEND_WEIGHT: blend_weight_reg <= cfg_data;
                    REG_GYRO_SENS:    gyro_sens_reg    <= cfg_data[SENS_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            angle_reg.angle_x <= lane_x;
            angle_reg.angle_y <= lane_y;
        end
    end

    assign angle_valid = angle_valid_reg;
    assign angle       = angle_reg;

    // roll: atan(ay / |(ax, az)|)
    cfilt_lane #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_lane_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .num   ({sample.accel_y[DATA_W-1], sample.accel_y}),
        .a     (sample.accel_x),
        .b     (sample.accel_z),
        .g     (sample.gyro_x),
        .dt    (sample.dt_ms),
        .den   (den),
        .alpha (alpha),
        .done  (done_x),
        .angle (lane_x)
    );

    // pitch: atan(-ax / |(ay, az)|)
    cfilt_lane #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_lane_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .num   (-{sample.accel_x[DATA_W-1], sample.accel_x}),
        .a     (sample.accel_y),
        .b     (sample.accel_z),
        .g     (sample.gyro_y),
        .dt    (sample.dt_ms),
        .den   (den),
        .alpha (alpha),
        .done  (done_y),
        .angle (lane_y)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import cfilt_pkg::*;

    // Angle table, Q16 degrees: atan(2^-i).
    localparam longint ATAN_TAB [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam int STEPS      = CORDIC_STEPS_DEF;
    localparam int LATENCY    = 84;
    localparam int CYCLE_CAP  = 2000000;

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_stall;
    sample_t              sample;
    logic                 angle_valid;
    logic                 angle_stall;
    angle_t               angle;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    imu_tilt_complementary_filter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .angle        (angle),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor state: registers and the two estimates.
    logic [ALPHA_W-1:0] alpha_reg;
    logic [SENS_W-1:0]  sens_reg;
    longint             roll_est;
    longint             pitch_est;

    sample_t pending_words[$];
    angle_t  expected_angles[$];
    int      errors;
    int      words_sent;
    int      words_issued;
    longint  cycles;

    // Floor shift right for signed values.
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned rem, res, b;
        rem = v;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Accelerometer tilt: atan(num / sqrt(a^2 + b^2)) in Q16 degrees.
    function automatic longint accel_tilt(longint num, longint a, longint b);
        longint x, y, z, dx, dy;
        x = int_sqrt(longint'(a * a + b * b) << 28);
        y = num * 16384;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint blend_angle(longint prev, longint g, longint dt, longint acc);
        longint unsigned den, mag;
        longint incr, a, sum, r;
        den = ((sens_reg == 0) ? 1 : sens_reg) * 100;
        mag = longint'(g < 0 ? -g : g) * dt * 65536;
        incr = longint'((mag + den / 2) / den);
        a = (alpha_reg > ALPHA_ONE) ? 65536 : alpha_reg;
        if (g < 0)
            incr = -incr;
        sum = a * (prev * 512 + incr) + (65536 - a) * acc + (64'sd1 << 24);
        r = floor_shr(sum, 25);
        if (r > ANGLE_LIMIT)
            r = ANGLE_LIMIT;
        if (r < -ANGLE_LIMIT)
            r = -ANGLE_LIMIT;
        return r;
    endfunction

    task automatic predict_angles(input sample_t s);
        angle_t r;
        longint ax, ay, az;
        ax = s.accel_x;
        ay = s.accel_y;
        az = s.accel_z;
        roll_est  = blend_angle(roll_est, s.gyro_x, s.dt_ms, accel_tilt(ay, ax, az));
        pitch_est = blend_angle(pitch_est, s.gyro_y, s.dt_ms, accel_tilt(-ax, ay, az));
        r.angle_x = roll_est[15:0];
        r.angle_y = pitch_est[15:0];
        expected_angles.push_back(r);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: bursts of words with random gaps, changes on the falling edge.
    int burst_left;
    int gap_left;
    logic hold_off;
    always @(negedge clk)
    begin
        if (sample_valid && (words_sent != words_issued))
        begin
            // stalled word holds
        end
        else if (hold_off || pending_words.size() == 0)
            sample_valid <= 1'b0;
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            sample_valid <= 1'b0;
        end
        else
        begin
            sample <= pending_words.pop_front();
            sample_valid <= 1'b1;
            words_issued <= words_issued + 1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            end
            else
                burst_left <= burst_left - 1;
        end
    end

    // Receiver stall pattern: periods of no stall, light stall and heavy stall.
    int stall_mode;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       angle_stall <= 1'b0;
            1:       angle_stall <= ($urandom_range(0, 3) == 0);
            default: angle_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Monitor: prediction on acceptance, check on result.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && sample_valid && !sample_stall)
        begin
            predict_angles(sample);
            words_sent <= words_sent + 1;
        end
        if (rst_n && angle_valid && !angle_stall)
        begin
            if (expected_angles.size() == 0)
            begin
                $display("%0t: unexpected word angle_x=%0d angle_y=%0d",
                         $time, angle.angle_x, angle.angle_y);
                errors++;
            end
            else
            begin
                angle_t e;
                e = expected_angles.pop_front();
                if (e.angle_x !== angle.angle_x)
                begin
                    $display("%0t: angle_x expected %0d actual %0d",
                             $time, e.angle_x, angle.angle_x);
                    errors++;
                end
                if (e.angle_y !== angle.angle_y)
                begin
                    $display("%0t: angle_y expected %0d actual %0d",
                             $time, e.angle_y, angle.angle_y);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** imu_tilt_complementary_filter_unit: FAILED **");
            $finish;
        end
    end

    function automatic sample_t make_word(int ax, int ay, int az, int gx, int gy, int dt);
        sample_t s;
        s.accel_x = ax[15:0];
        s.accel_y = ay[15:0];
        s.accel_z = az[15:0];
        s.gyro_x  = gx[15:0];
        s.gyro_y  = gy[15:0];
        s.dt_ms   = dt[15:0];
        return s;
    endfunction

    function automatic sample_t random_word();
        sample_t s;
        int g;
        s = make_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        // Mostly realistic: bounded x and y acceleration, small dt, modest rates.
        if ($urandom_range(0, 3) != 0)
        begin
            g = $urandom_range(0, 300);
            s.accel_x = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
            s.accel_y = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
            s.gyro_x  = $signed(16'($urandom_range(0, 2 * g))) - 16'(g);
            s.gyro_y  = $signed(16'($urandom_range(0, 2 * g))) - 16'(g);
            s.dt_ms   = 16'($urandom_range(0, 50));
        end
        return s;
    endfunction

    // Register write while the block is idle; the predictor follows.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BLEND_WEIGHT)
            alpha_reg = val;
        else if (idx == REG_GYRO_SENS)
            sens_reg = val[SENS_W-1:0];
    endtask

    // Let every queued word go through and the block settle.
    task automatic drain();
        while (pending_words.size() != 0 || words_sent != words_issued
               || expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            pending_words.push_back(random_word());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        angle_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        words_sent = 0;
        words_issued = 0;
        cycles = 0;
        burst_left = 1;
        gap_left = 0;
        hold_off = 1'b0;
        stall_mode = 0;
        alpha_reg = BLEND_WEIGHT_RST;
        sens_reg = GYRO_SENS_RST;
        roll_est = 0;
        pitch_est = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero vector, zero denominators, extremes, saturation.
        pending_words.push_back(make_word(0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(0, 1000, 0, 0, 0, 10));
        pending_words.push_back(make_word(-1000, 0, 0, 0, 0, 10));
        pending_words.push_back(make_word(0, 0, 8192, 0, 0, 10));
        pending_words.push_back(make_word(-32768, -32768, -32768, -32768, -32768, 65535));
        pending_words.push_back(make_word(32767, 32767, 32767, 32767, 32767, 65535));
        pending_words.push_back(make_word(-32768, 32767, 0, 32767, -32768, 65535));
        pending_words.push_back(make_word(32767, -32768, -32768, -1, 1, 1));
        pending_words.push_back(make_word(0, -32768, 0, -32768, 32767, 0));
        pending_words.push_back(make_word(1, 1, 1, 1, -1, 1));
        pending_words.push_back(make_word(-1, -1, -1, 0, 0, 65535));
        drain();

        // Pure gyro path, and zero sensitivity is treated as one.
        write_reg(REG_BLEND_WEIGHT, 17'd65536);
        write_reg(REG_GYRO_SENS, 16'd0);
        pending_words.push_back(make_word(100, 200, 8192, 32767, -32768, 65535));
        pending_words.push_back(make_word(100, 200, 8192, -32768, 32767, 65535));
        pending_words.push_back(make_word(100, 200, 8192, 5, -5, 3));
        random_phase(60);

        // Weight above one clamps; maximum sensitivity.
        write_reg(REG_BLEND_WEIGHT, 17'h1FFFF);
        write_reg(REG_GYRO_SENS, 16'hFFFF);
        random_phase(60);

        // Accelerometer only.
        write_reg(REG_BLEND_WEIGHT, 17'd0);
        write_reg(REG_GYRO_SENS, 16'd1);
        random_phase(60);

        // Unlisted register index is ignored by the block.
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 2'd3;
        cfg_data <= '1;
        @(negedge clk);
        cfg_we <= 1'b0;

        write_reg(REG_BLEND_WEIGHT, 17'd32768);
        write_reg(REG_GYRO_SENS, 16'd1310);
        random_phase(100);

        write_reg(REG_BLEND_WEIGHT, BLEND_WEIGHT_RST);
        write_reg(REG_GYRO_SENS, GYRO_SENS_RST);
        random_phase(270);

        if (errors == 0)
            $display("** imu_tilt_complementary_filter_unit: PASSED **");
        else
            $display("** imu_tilt_complementary_filter_unit: FAILED **");
        $finish;
    end

endmodule
